FILE: rtl/vsra_pkg.sv
`default_nettype none

package vsra_pkg;

  // defaults for the top-level parameters
  localparam int MAX_EXTENT_DEF   = 1024;
  localparam int MAX_CHANNELS_DEF = 4;

  // fixed field widths
  localparam int ADDR_W    = 30;
  localparam int VALUE_W   = 32;
  localparam int SIZE_W    = 11;
  localparam int CHAN_W    = 3;
  localparam int ORIENT_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;

  // queue depths
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS    = 3'd4;

  // orientation codes, the unused code behaves as axial
  localparam logic [ORIENT_W-1:0] ORIENT_AXIAL    = 2'd0;
  localparam logic [ORIENT_W-1:0] ORIENT_SAGITTAL = 2'd1;
  localparam logic [ORIENT_W-1:0] ORIENT_CORONAL  = 2'd2;

  // width of an effective extent (1 .. max_ext)
  function automatic int ext_w(input int max_ext);
    return $clog2(max_ext + 1);
  endfunction

  // width of a position counter (0 .. max_ext-1)
  function automatic int cnt_w(input int max_ext);
    return $clog2(max_ext);
  endfunction

  // width of an effective channel count (1 .. max_ch)
  function automatic int ch_w(input int max_ch);
    return $clog2(max_ch + 1);
  endfunction

  // width of the channel plane counter
  function automatic int ci_w(input int max_ch);
    return (max_ch > 1) ? $clog2(max_ch) : 1;
  endfunction

  // width of channels*x + c
  function automatic int e_w(input int max_ext, input int max_ch);
    return $clog2(max_ext * max_ch + 1);
  endfunction

  // work token between front and back: a, b, c, d, e, value, last
  function automatic int tok_w(input int max_ext, input int max_ch);
    return cnt_w(max_ext) + 3 * ext_w(max_ext) + e_w(max_ext, max_ch) + VALUE_W + 1;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/vsra_div.sv
`default_nettype none

module vsra_div import vsra_pkg::*; #(
  parameter int DIVIDEND_W = 11,
  parameter int DIVISOR_W  = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       busy,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0] rem;
  logic [STEP_W-1:0]    steps;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  // restoring division, one quotient bit per cycle, dividend shifts out of quotient
  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      steps    <= '0;
      rem      <= '0;
      quotient <= DIVIDEND_W'(1);
    end else if (start) begin
      busy     <= 1'b1;
      steps    <= STEP_W'(DIVIDEND_W);
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= DIVISOR_W'(trial - {1'b0, divisor});
      end else begin
        rem <= DIVISOR_W'(trial);
      end
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
      steps    <= steps - STEP_W'(1);
      busy     <= steps != STEP_W'(1);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vsra_fifo.sv
`default_nettype none

module vsra_fifo import vsra_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               do_wr;
  logic               do_rd;

  assign full    = count == COUNT_W'(DEPTH);
  assign empty   = count == '0;
  assign do_wr   = push && !full;
  assign do_rd   = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + COUNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vsra_front.sv
`default_nettype none

module vsra_front import vsra_pkg::*; #(
  parameter int MAX_EXTENT   = MAX_EXTENT_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cfg_write,
  input  wire logic [CFG_IDX_W-1:0]                    cfg_index,
  input  wire logic [CFG_DAT_W-1:0]                    cfg_data,
  input  wire logic                                    push,
  output logic                                         full,
  input  wire logic [VALUE_W-1:0]                      in_value,
  input  wire logic                                    tok_full,
  output logic                                         tok_push,
  output logic [tok_w(MAX_EXTENT, MAX_CHANNELS)-1:0]   tok_data
);

  localparam int EXT_W = ext_w(MAX_EXTENT);
  localparam int CNT_W = cnt_w(MAX_EXTENT);
  localparam int CH_W  = ch_w(MAX_CHANNELS);
  localparam int CI_W  = ci_w(MAX_CHANNELS);
  localparam int E_W   = e_w(MAX_EXTENT, MAX_CHANNELS);

  logic [ORIENT_W-1:0] orientation;
  logic [SIZE_W-1:0]   size_x;
  logic [SIZE_W-1:0]   size_y;
  logic [SIZE_W-1:0]   size_z;
  logic [CHAN_W-1:0]   channels;

  logic                restart;
  logic                div_start;
  logic                div_busy;
  logic [EXT_W-1:0]    group_total;

  logic [CNT_W-1:0]    col_count;
  logic [CNT_W-1:0]    row_count;
  logic [CNT_W-1:0]    group_count;
  logic [CNT_W-1:0]    slice_count;
  logic [CI_W-1:0]     chan_count;
  logic [CNT_W-1:0]    col_count_next;
  logic [CNT_W-1:0]    row_count_next;
  logic [CNT_W-1:0]    group_count_next;
  logic [CNT_W-1:0]    slice_count_next;
  logic [CI_W-1:0]     chan_count_next;

  logic [EXT_W-1:0]    sx;
  logic [EXT_W-1:0]    sy;
  logic [EXT_W-1:0]    sz;
  logic [CH_W-1:0]     ch_eff;
  logic [CH_W-1:0]     ch_use;
  logic                sag;
  logic                accept;
  logic                col_wrap;
  logic                row_wrap;
  logic                chan_wrap;
  logic                last;
  logic                produce;

  logic [CNT_W-1:0]    op_a;
  logic [EXT_W-1:0]    op_b;
  logic [EXT_W-1:0]    op_c;
  logic [EXT_W-1:0]    op_d;
  logic [E_W-1:0]      op_e;

  function automatic logic [EXT_W-1:0] eff_ext(input logic [SIZE_W-1:0] v);
    if (v == '0) begin
      return EXT_W'(1);
    end
    if (int'(v) > MAX_EXTENT) begin
      return EXT_W'(MAX_EXTENT);
    end
    return EXT_W'(v);
  endfunction

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      orientation <= ORIENT_AXIAL;
      size_x      <= SIZE_W'(1);
      size_y      <= SIZE_W'(1);
      size_z      <= SIZE_W'(1);
      channels    <= CHAN_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ORIENTATION: orientation <= cfg_data[ORIENT_W-1:0];
        REG_SIZE_X:      size_x      <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Y:      size_y      <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Z:      size_z      <= cfg_data[SIZE_W-1:0];
        REG_CHANNELS:    channels    <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_write && (cfg_index == REG_ORIENTATION || cfg_index == REG_SIZE_X ||
                                 cfg_index == REG_SIZE_Y || cfg_index == REG_SIZE_Z ||
                                 cfg_index == REG_CHANNELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= restart;
    end
  end

  // group count = size_z / channels
  vsra_div #(
    .DIVIDEND_W(EXT_W),
    .DIVISOR_W (CH_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sz),
    .divisor (ch_eff),
    .busy    (div_busy),
    .quotient(group_total)
  );

  assign sx = eff_ext(size_x);
  assign sy = eff_ext(size_y);
  assign sz = eff_ext(size_z);

  always_comb begin
    if (channels == '0) begin
      ch_eff = CH_W'(1);
    end else if (int'(channels) > MAX_CHANNELS) begin
      ch_eff = CH_W'(MAX_CHANNELS);
    end else begin
      ch_eff = CH_W'(channels);
    end
  end

  assign sag    = orientation == ORIENT_SAGITTAL;
  assign ch_use = sag ? ch_eff : CH_W'(1);

  assign full   = div_start || div_busy || tok_full;
  assign accept = push && !full;

  // classify the voxel at the current position
  assign col_wrap  = (EXT_W'(col_count) + EXT_W'(1)) >= sx;
  assign row_wrap  = (EXT_W'(row_count) + EXT_W'(1)) >= sy;
  assign chan_wrap = (CH_W'(chan_count) + CH_W'(1)) >= ch_use;
  assign last      = col_wrap && row_wrap && ((EXT_W'(slice_count) + EXT_W'(1)) >= sz);
  assign produce   = !sag || (EXT_W'(group_count) < group_total);

  always_comb begin
    col_count_next   = col_count + CNT_W'(1);
    row_count_next   = row_count;
    chan_count_next  = chan_count;
    group_count_next = group_count;
    slice_count_next = slice_count;
    if (last) begin
      col_count_next   = '0;
      row_count_next   = '0;
      chan_count_next  = '0;
      group_count_next = '0;
      slice_count_next = '0;
    end else if (col_wrap) begin
      col_count_next = '0;
      row_count_next = row_count + CNT_W'(1);
      if (row_wrap) begin
        row_count_next   = '0;
        slice_count_next = slice_count + CNT_W'(1);
        chan_count_next  = chan_count + CI_W'(1);
        if (chan_wrap) begin
          chan_count_next  = '0;
          group_count_next = group_count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_count   <= '0;
      row_count   <= '0;
      chan_count  <= '0;
      group_count <= '0;
      slice_count <= '0;
    end else if (accept) begin
      col_count   <= col_count_next;
      row_count   <= row_count_next;
      chan_count  <= chan_count_next;
      group_count <= group_count_next;
      slice_count <= slice_count_next;
    end
  end

  // every mode reduces to a + b*(c + d*e)
  always_comb begin
    unique case (orientation)
      ORIENT_SAGITTAL: begin
        op_a = row_count;
        op_b = sy;
        op_c = group_total - EXT_W'(group_count) - EXT_W'(1);
        op_d = group_total;
        op_e = E_W'(ch_use) * E_W'(col_count) + E_W'(chan_count);
      end
      ORIENT_CORONAL: begin
        op_a = col_count;
        op_b = sx;
        op_c = (EXT_W'(slice_count) < sz) ? (sz - EXT_W'(slice_count) - EXT_W'(1)) : '0;
        op_d = sz;
        op_e = E_W'(row_count);
      end
      default: begin
        op_a = col_count;
        op_b = sx;
        op_c = EXT_W'(row_count);
        op_d = sy;
        op_e = E_W'(slice_count);
      end
    endcase
  end

  assign tok_push = accept && produce;
  assign tok_data = {op_a, op_b, op_c, op_d, op_e, in_value, last};

endmodule

`default_nettype wire

FILE: rtl/vsra_back.sv
`default_nettype none

module vsra_back import vsra_pkg::*; #(
  parameter int MAX_EXTENT   = MAX_EXTENT_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   tok_valid,
  input  wire logic [tok_w(MAX_EXTENT, MAX_CHANNELS)-1:0] tok_data,
  output logic                                        tok_pop,
  input  wire logic                                   pop,
  output logic                                        empty,
  output logic [ADDR_W-1:0]                           out_address,
  output logic [VALUE_W-1:0]                          out_value,
  output logic                                        volume_end
);

  localparam int EXT_W = ext_w(MAX_EXTENT);
  localparam int CNT_W = cnt_w(MAX_EXTENT);
  localparam int E_W   = e_w(MAX_EXTENT, MAX_CHANNELS);
  localparam int SUM_W = EXT_W + E_W + 1;
  localparam int RES_W = ADDR_W + VALUE_W + 1;

  logic [CNT_W-1:0]   t_a;
  logic [EXT_W-1:0]   t_b;
  logic [EXT_W-1:0]   t_c;
  logic [EXT_W-1:0]   t_d;
  logic [E_W-1:0]     t_e;
  logic [VALUE_W-1:0] t_value;
  logic               t_last;
  logic [SUM_W-1:0]   t_inner;

  logic               s1_valid;
  logic [CNT_W-1:0]   s1_a;
  logic [EXT_W-1:0]   s1_b;
  logic [ADDR_W-1:0]  s1_inner;
  logic [VALUE_W-1:0] s1_value;
  logic               s1_last;

  logic               s2_valid;
  logic [ADDR_W-1:0]  s2_address;
  logic [VALUE_W-1:0] s2_value;
  logic               s2_last;

  logic               res_full;
  logic               s1_free;
  logic               s2_free;
  logic [RES_W-1:0]   res_data;

  assign {t_a, t_b, t_c, t_d, t_e, t_value, t_last} = tok_data;

  assign s2_free = !s2_valid || !res_full;
  assign s1_free = !s1_valid || s2_free;
  assign tok_pop = tok_valid && s1_free;

  // first product: c + d*e
  assign t_inner = SUM_W'(t_c) + SUM_W'(t_d) * SUM_W'(t_e);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= tok_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_a     <= t_a;
      s1_b     <= t_b;
      s1_inner <= ADDR_W'(t_inner);
      s1_value <= t_value;
      s1_last  <= t_last;
    end
  end

  // second product: a + b*inner, kept modulo the address width
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_address <= ADDR_W'(s1_a) + ADDR_W'(s1_b) * s1_inner;
      s2_value   <= s1_value;
      s2_last    <= s1_last;
    end
  end

  vsra_fifo #(
    .WIDTH(RES_W),
    .DEPTH(OUT_DEPTH)
  ) u_res_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (s2_valid),
    .wr_data({s2_address, s2_value, s2_last}),
    .full   (res_full),
    .pop    (pop),
    .rd_data(res_data),
    .empty  (empty)
  );

  assign {out_address, out_value, volume_end} = res_data;

endmodule

`default_nettype wire

FILE: rtl/volume_slice_reorient_address.sv
// Address generator for reslicing a volume along permuted axes. Voxels are pushed in input
// raster order (x fastest, then y, then slice) and come out in the same order with the
// linear address they take in the reoriented volume: axial copies, sagittal permutes the
// axes over groups of interleaved channel planes with the group axis flipped, coronal swaps
// y and z and flips z. In sagittal mode the slices beyond a whole number of channel groups
// are taken but give no result, so such a volume never reports volume_end. The block
// accepts one voxel per cycle as long as results are popped and no group count is being
// recomputed; a result passes the token queue, two multiplier stages and the result
// queue. Each write to a known register restarts the volume and reruns the bit-serial
// divider that yields the group count, so full stays high after the write until the
// divider is done.
`default_nettype none

module volume_slice_reorient_address import vsra_pkg::*; #(
  parameter int MAX_EXTENT   = MAX_EXTENT_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  // voxel input queue side
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [VALUE_W-1:0]   in_value,
  // result queue side
  input  wire logic                 pop,
  output logic                      empty,
  output logic [ADDR_W-1:0]         out_address,
  output logic [VALUE_W-1:0]        out_value,
  output logic                      volume_end
);

  localparam int TOK_W = tok_w(MAX_EXTENT, MAX_CHANNELS);

  logic             tok_push;
  logic [TOK_W-1:0] tok_wr_data;
  logic             tok_full;
  logic             tok_empty;
  logic             tok_pop;
  logic [TOK_W-1:0] tok_rd_data;

  // register writes taken in any cycle; block must be configured while idle, not enforced
  assign cfg_ready = 1'b1;

  // front: registers, position counters, group divider, operand selection
  vsra_front #(
    .MAX_EXTENT  (MAX_EXTENT),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_value (in_value),
    .tok_full (tok_full),
    .tok_push (tok_push),
    .tok_data (tok_wr_data)
  );

  // short queue so front and back stall independently
  vsra_fifo #(
    .WIDTH(TOK_W),
    .DEPTH(MID_DEPTH)
  ) u_tok_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (tok_push),
    .wr_data(tok_wr_data),
    .full   (tok_full),
    .pop    (tok_pop),
    .rd_data(tok_rd_data),
    .empty  (tok_empty)
  );

  // back: two multiply stages and the result queue
  vsra_back #(
    .MAX_EXTENT  (MAX_EXTENT),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .tok_valid  (!tok_empty),
    .tok_data   (tok_rd_data),
    .tok_pop    (tok_pop),
    .pop        (pop),
    .empty      (empty),
    .out_address(out_address),
    .out_value  (out_value),
    .volume_end (volume_end)
  );

endmodule

`default_nettype wire

FILE: rtl/vsra_checker.sv
`default_nettype none

module vsra_checker import vsra_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [CFG_DAT_W-1:0] cfg_data,
  input wire logic                 push,
  input wire logic                 full,
  input wire logic [VALUE_W-1:0]   in_value,
  input wire logic                 pop,
  input wire logic                 empty,
  input wire logic [ADDR_W-1:0]    out_address,
  input wire logic [VALUE_W-1:0]   out_value,
  input wire logic                 volume_end
);

  logic known_write;

  assign known_write = cfg_valid && cfg_ready &&
                       (cfg_index == REG_ORIENTATION || cfg_index == REG_SIZE_X ||
                        cfg_index == REG_SIZE_Y || cfg_index == REG_SIZE_Z ||
                        cfg_index == REG_CHANNELS);

  // nothing waits and input is open right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("block not idle after reset");

  // register write holds off input while the group count is recomputed
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    known_write |=> full ##1 full)
    else $error("input open during group count update");

  // a waiting result does not change until popped
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_address) && $stable(out_value) &&
                          $stable(volume_end)))
    else $error("waiting result changed");

  // no result can appear before a voxel has passed the whole pipeline
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    ($fell(empty) && $past(empty, 2) && $past(empty, 3)) |->
      ($past(push && !full, 4) || $past(!empty, 4)))
    else $error("result appeared without a voxel");

endmodule

bind volume_slice_reorient_address vsra_checker u_vsra_checker (.*);

`default_nettype wire
